/* rtl/amdh_pkg.sv */
// Package for the AES-128 based Merkle-Damgard hash block.
// Holds payload structs, queue entry type, state enums, constants and the AES S-box.
// No dependencies.
package amdh_pkg;

   localparam logic [31:0] INIT_VALUE_RESET = 32'h7856_3412;
   localparam int QueueDepth = 4;
   localparam logic [7:0] PAD_MARKER = 8'h80;

   localparam logic CSR_INITIAL_VALUE = 1'b0;
   localparam logic CSR_PAD_ENABLE    = 1'b1;

   typedef struct packed {
      logic [31:0] chain_in;
      logic        start_from_chain;
      logic        last_byte;
      logic        byte_valid;
      logic [7:0]  message_byte;
   } req_word_type;

   typedef struct packed {
      logic        partial_dropped;
      logic [31:0] hash_out;
   } rsp_word_type;

   typedef enum logic [1:0] {
      JOB_BLOCK  = 2'd0,
      JOB_FINAL  = 2'd1,
      JOB_FINAL2 = 2'd2
   } job_kind_type;

   // One queued job: up to two blocks to compress and, optionally, a result to emit after them.
   typedef struct packed {
      job_kind_type  kind;
      logic          load_chain;
      logic [31:0]   chain;
      logic [127:0]  block;
      logic [127:0]  block2;
      logic          compress;
      logic          dropped;
   } job_type;

   typedef enum logic [1:0] {
      BE_IDLE  = 2'd0,
      BE_RUN   = 2'd1,
      BE_RESP  = 2'd2
   } be_state_type;

   function automatic logic [7:0] sbox(input logic [7:0] x);
      logic [7:0] t [256];
      t = '{
 8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
 8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
 8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
 8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
 8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
 8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
 8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
 8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
 8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
 8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
 8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
 8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
 8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
 8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
 8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
 8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
      return t[x];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] v);
      return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
   endfunction

endpackage

/* rtl/amdh_front.sv */
// Front end: packs bytes into blocks, tracks length and builds padding jobs.
// Depends on amdh_pkg.
module amdh_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  amdh_pkg::req_word_type req_word,
   input  logic [31:0]           initial_value,
   input  logic                  pad_enable,
   output logic                  job_valid,
   input  logic                  job_full,
   output amdh_pkg::job_type     job
);
   import amdh_pkg::*;

   logic [7:0]  buffer_ff [16];
   logic [3:0]  fill_ff;
   logic [63:0] length_ff;
   logic        in_message_ff;

   logic        accept;
   logic        first;
   logic [4:0]  fill_next;
   logic [3:0]  fill_in;
   logic [63:0] length_in;
   logic [7:0]  blk [16];
   logic [127:0] full_block;
   logic [127:0] pad_block;
   logic [127:0] len_block;

   assign req_stall = job_full;
   assign accept = req_valid && !req_stall;
   assign first = !in_message_ff;

   always_comb begin
      fill_next = {1'b0, first ? 4'd0 : fill_ff} + {4'd0, req_word.byte_valid};
      length_in = (first ? 64'd0 : length_ff) + {63'd0, req_word.byte_valid};
      fill_in = fill_next[3:0];
      for (int i = 0; i < 16; i++) begin
         blk[i] = buffer_ff[i];
      end
      if (req_word.byte_valid) begin
         blk[first ? 4'd0 : fill_ff] = req_word.message_byte;
      end
      for (int i = 0; i < 16; i++) begin
         full_block[8*i +: 8] = blk[i];
         pad_block[8*i +: 8] = (5'(i) < {1'b0, fill_in}) ? blk[i] : 8'h00;
         len_block[8*i +: 8] = 8'h00;
      end
      pad_block[8*fill_in +: 8] = PAD_MARKER;
      len_block[127:64] = length_in;
      if (fill_in <= 4'd8) begin
         pad_block[127:64] = length_in;
      end
   end

   always_comb begin
      job = '0;
      job.load_chain = first;
      job.chain = req_word.start_from_chain ? req_word.chain_in : initial_value;
      job.block = full_block;
      job.block2 = len_block;
      job.compress = fill_next[4];
      job.kind = JOB_BLOCK;
      job.dropped = 1'b0;
      job_valid = 1'b0;
      if (accept) begin
         if (req_word.last_byte) begin
            job_valid = 1'b1;
            if (pad_enable) begin
               job.block = pad_block;
               job.compress = 1'b1;
               job.kind = (fill_in <= 4'd8) ? JOB_FINAL : JOB_FINAL2;
            end else begin
               job.kind = JOB_FINAL;
               job.dropped = (fill_in != 4'd0);
            end
            // A full block completed by this item is still hashed first.
            if (fill_next[4]) begin
               job.block2 = full_block;
               job.kind = pad_enable ? JOB_FINAL2 : JOB_FINAL;
               job.compress = 1'b1;
               if (pad_enable) begin
                  job.block = full_block;
                  job.block2 = pad_block;
               end
            end
         end else if (fill_next[4] || first) begin
            job_valid = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         length_ff <= '0;
         in_message_ff <= 1'b0;
      end else if (accept) begin
         fill_ff <= req_word.last_byte ? 4'd0 : fill_in;
         length_ff <= length_in;
         in_message_ff <= !req_word.last_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_word.byte_valid) begin
         buffer_ff[first ? 4'd0 : fill_ff] <= req_word.message_byte;
      end
   end

`ifndef SYNTH
   a_fill_cleared_after_last: assert property (@(posedge clock) disable iff (reset)
      accept && req_word.last_byte |=> fill_ff == 4'd0 && !in_message_ff)
      else $error("fill not cleared after last");
   a_job_when_last: assert property (@(posedge clock) disable iff (reset)
      accept && req_word.last_byte |-> job_valid)
      else $error("last item produced no job");
   a_no_job_when_stalled: assert property (@(posedge clock) disable iff (reset)
      job_full |-> !job_valid)
      else $error("job pushed into full queue");
`endif
endmodule

/* rtl/amdh_back.sv */
// Back end: job queue, round-per-cycle AES-128 compression and result register.
// Depends on amdh_pkg.
module amdh_back #(
   parameter int QUEUE_DEPTH = amdh_pkg::QueueDepth
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  job_valid,
   output logic                  job_full,
   input  amdh_pkg::job_type     job,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output amdh_pkg::rsp_word_type rsp_word
);
   import amdh_pkg::*;

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   job_type       queue_ff [QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [PW:0]   count_ff;
   logic          pop;
   job_type       head;

   be_state_type  state_ff, state_in;
   logic [31:0]   chain_ff;
   logic [127:0]  st_ff;
   logic [127:0]  rk_ff;
   logic [7:0]    rcon_ff;
   logic [3:0]    round_ff;
   logic          second_ff;
   job_type       cur_ff;
   rsp_word_type  rsp_ff;
   logic          rsp_valid_ff;

   logic [127:0]  st_round;
   logic [127:0]  rk_next;
   logic [127:0]  key0;
   logic [7:0]    t [16];
   logic [7:0]    m [16];
   logic [31:0]   base_chain;
   logic          start_run;
   logic          finish;

   assign head = queue_ff[rd_ptr_ff];
   assign job_full = (count_ff >= (PW+1)'(QUEUE_DEPTH - 1));
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word = rsp_ff;

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            t[r + 4*c] = sbox(st_ff[8*(r + 4*((c + r) % 4)) +: 8]);
         end
      end
      for (int c = 0; c < 4; c++) begin
         logic [7:0] all;
         all = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
         m[4*c]   = t[4*c]   ^ all ^ xtime(t[4*c]   ^ t[4*c+1]);
         m[4*c+1] = t[4*c+1] ^ all ^ xtime(t[4*c+1] ^ t[4*c+2]);
         m[4*c+2] = t[4*c+2] ^ all ^ xtime(t[4*c+2] ^ t[4*c+3]);
         m[4*c+3] = t[4*c+3] ^ all ^ xtime(t[4*c+3] ^ t[4*c]);
      end
      rk_next[31:0] = rk_ff[31:0] ^ {sbox(rk_ff[103:96]), sbox(rk_ff[127:120]),
                                     sbox(rk_ff[119:112]),
                                     sbox(rk_ff[111:104]) ^ rcon_ff};
      for (int w = 1; w < 4; w++) begin
         rk_next[32*w +: 32] = rk_ff[32*w +: 32] ^ rk_next[32*(w-1) +: 32];
      end
      for (int i = 0; i < 16; i++) begin
         st_round[8*i +: 8] = ((round_ff == 4'd10) ? t[i] : m[i]) ^ rk_next[8*i +: 8];
      end
   end

   // Compress the head job's first block, or finish a job that needs no AES.
   assign start_run = (state_ff == BE_IDLE) && (count_ff != '0);
   assign finish = (state_ff == BE_RUN) && (round_ff == 4'd10);
   assign base_chain = head.load_chain ? head.chain : chain_ff;
   assign key0 = {96'd0, base_chain};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BE_IDLE: begin
            if (count_ff != '0) begin
               if (head.compress) state_in = BE_RUN;
               else if (head.kind != JOB_BLOCK) state_in = BE_RESP;
            end
         end
         BE_RUN: begin
            if (finish) begin
               if (cur_ff.kind == JOB_FINAL2 && !second_ff) state_in = BE_RUN;
               else if (cur_ff.kind == JOB_BLOCK) state_in = BE_IDLE;
               else state_in = BE_RESP;
            end
         end
         BE_RESP: if (!rsp_valid_ff) state_in = BE_IDLE;
         default: state_in = BE_IDLE;
      endcase
   end

   assign pop = start_run;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BE_IDLE;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (job_valid) wr_ptr_ff <= (wr_ptr_ff == PW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
         if (pop) rd_ptr_ff <= (rd_ptr_ff == PW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
         count_ff <= count_ff + {{PW{1'b0}}, job_valid} - {{PW{1'b0}}, pop};
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         else if (state_ff == BE_RESP && !rsp_valid_ff) rsp_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (job_valid) queue_ff[wr_ptr_ff] <= job;
      if (start_run) begin
         cur_ff <= head;
         chain_ff <= base_chain;
         st_ff <= head.block ^ key0;
         rk_ff <= key0;
         rcon_ff <= 8'h01;
         round_ff <= 4'd1;
         second_ff <= 1'b0;
      end else if (state_ff == BE_RUN) begin
         if (finish) begin
            chain_ff <= st_round[31:0];
            second_ff <= 1'b1;
            st_ff <= cur_ff.block2 ^ {96'd0, st_round[31:0]};
            rk_ff <= {96'd0, st_round[31:0]};
            rcon_ff <= 8'h01;
            round_ff <= 4'd1;
         end else begin
            st_ff <= st_round;
            rk_ff <= rk_next;
            rcon_ff <= xtime(rcon_ff);
            round_ff <= round_ff + 4'd1;
         end
      end
      if (state_ff == BE_RESP && !rsp_valid_ff) begin
         rsp_ff.hash_out <= chain_ff;
         rsp_ff.partial_dropped <= cur_ff.dropped;
      end
   end

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (PW+1)'(QUEUE_DEPTH))
      else $error("queue overflow");
   a_rsp_only_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == BE_RESP)
      else $error("response outside respond state");
   a_round_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == BE_RUN |-> round_ff >= 4'd1 && round_ff <= 4'd10)
      else $error("round counter out of range");
`endif
endmodule

/* rtl/aes_merkle_damgard_hash_top.sv */
// A last word's job waits in the queue, the back end compresses its blocks one after the other,
// and the hash is then registered for the response; a final job with no block to compress goes
// straight to the response. Bytes that complete no block are taken one per cycle; the single
// round-per-cycle AES unit compresses one block at a time, which sets throughput, and the input
// stalls while QUEUE_DEPTH-1 or more jobs wait in the queue. Synchronous active-high reset clears
// control state and sets initial_value to 0x78563412 and pad_enable to 1.
module aes_merkle_damgard_hash_top #(
   parameter int QUEUE_DEPTH = amdh_pkg::QueueDepth
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  amdh_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output amdh_pkg::rsp_word_type rsp_word,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_index,
   input  logic [31:0]            csr_data
);
   import amdh_pkg::*;

   logic [31:0] initial_value_ff;
   logic        pad_enable_ff;
   logic        job_valid;
   logic        job_full;
   job_type     job;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         initial_value_ff <= INIT_VALUE_RESET;
         pad_enable_ff <= 1'b1;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_INITIAL_VALUE: initial_value_ff <= csr_data;
            CSR_PAD_ENABLE:    pad_enable_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   amdh_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .initial_value(initial_value_ff), .pad_enable(pad_enable_ff),
      .job_valid(job_valid), .job_full(job_full), .job(job)
   );

   amdh_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
      .clock(clock), .reset(reset),
      .job_valid(job_valid), .job_full(job_full), .job(job),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word)
   );
endmodule
